### hw/rtl/asetk_pkg.sv
// Shared types and constants for the action state edge tracker.
// No dependencies; the top level, state memory, sample unit and bench import this package.
package asetk_pkg;

    // Item codes
    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_SAMPLE = 2'd1,
        MODE_END    = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DIRECT = 2'd0,
        KIND_BUTTON = 2'd1,
        KIND_AXIS   = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_SAMPLE  = 2'd1,
        ST_WALK_RD = 2'd2,
        ST_WALK_WR = 2'd3
    } t_state;

    localparam int SUM_W   = 20;
    localparam int LEVEL_W = 16;
    localparam int DZ_W    = 15;

    localparam logic [DZ_W-1:0]         DEADZONE_RESET = 15'd4096;
    localparam logic signed [SUM_W:0]   SUM_MAX        = 21'sd524287;
    localparam logic signed [SUM_W:0]   SUM_MIN        = -21'sd524288;
    localparam logic signed [SUM_W-1:0] ONE_Q14        = 20'sd16384;
    localparam logic signed [SUM_W-1:0] MINUS_ONE_Q14  = -20'sd16384;
    localparam logic [31:0]             ROUND_HALF     = 32'd2048;

    // One stored action entry
    typedef struct packed {
        logic                    held_now;
        logic                    held_before;
        logic signed [SUM_W-1:0] sum;
    } t_entry;

    // Registered sample operands handed to the sample unit
    typedef struct packed {
        t_kind              kind;
        logic               down;
        logic signed [15:0] sample_value;
        logic signed [15:0] scale;
        logic signed [31:0] product;
    } t_sample;

endpackage

### hw/rtl/asetk_if.sv
// Valid/ready channel interfaces for the action state edge tracker.
// Depends on nothing; used by the top level ports.
interface asetk_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [5:0]         action;
    logic [1:0]         kind;
    logic               present;
    logic               button_down;
    logic signed [15:0] sample_value;
    logic signed [15:0] scale;

    modport source (
        output valid, mode, action, kind, present, button_down, sample_value, scale,
        input  ready
    );
    modport sink (
        input  valid, mode, action, kind, present, button_down, sample_value, scale,
        output ready
    );
endinterface

interface asetk_out_if;
    logic               valid;
    logic               ready;
    logic [5:0]         report_action;
    logic               held;
    logic               went_down;
    logic               went_up;
    logic signed [15:0] level;
    logic               last;

    modport source (
        output valid, report_action, held, went_down, went_up, level, last,
        input  ready
    );
    modport sink (
        input  valid, report_action, held, went_down, went_up, level, last,
        output ready
    );
endinterface

### hw/rtl/action_state_edge_tracker.sv
// Top level of the action state edge tracker: sequencer, deadzone register, report word.
// Depends on asetk_pkg, asetk_if, asetk_state_mem and asetk_sample_alu.
//
//  channel   dir  protocol      word
//  i_in      in   valid/ready   mode, action, kind, present, button_down, sample_value, scale
//  o_out     out  valid/ready   report_action, held, went_down, went_up, level, last
//  i_cfg_*   in   write enable  deadzone (15 bit)
//
// A sample is a memory read, then modify and write back.
// Frame start and frame end walk all actions, with a read then a write per action;
// an ignored item is accepted in idle and starts no sequence.
// A frame end walk holds on a stalled output word; no item is taken meanwhile.
// Reset (synchronous, active low) clears the per-entry valid bits: no clearing pass.
module action_state_edge_tracker #(
    parameter int ACTION_COUNT = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    asetk_in_if.sink                    i_in,
    asetk_out_if.source                 o_out,
    input  logic                        i_cfg_we,
    input  logic [asetk_pkg::DZ_W-1:0]  i_cfg_wdata
);
    import asetk_pkg::*;

    localparam int AW = (ACTION_COUNT > 1) ? $clog2(ACTION_COUNT) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(ACTION_COUNT - 1);

    t_state            r_state, n_state;
    logic [DZ_W-1:0]   r_deadzone;
    logic [AW-1:0]     r_idx, n_idx;
    logic              r_walk_end;
    logic [AW-1:0]     r_addr;
    t_sample           r_smp;

    logic              in_acc;
    logic              smp_ok;
    logic              out_free;
    logic              walk_go;
    logic              rd_en, wr_en, out_load;
    logic [AW-1:0]     rd_addr, wr_addr;
    t_entry            rd_data, wr_data, alu_new;
    logic signed [SUM_W-1:0] clamped;

    logic              r_out_valid;
    logic [5:0]        r_out_action;
    logic              r_out_held, r_out_down, r_out_up, r_out_last;
    logic signed [LEVEL_W-1:0] r_out_level;

    // Deadzone register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone <= DEADZONE_RESET;
        end else if (i_cfg_we) begin
            r_deadzone <= i_cfg_wdata;
        end
    end

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign smp_ok     = (t_mode'(i_in.mode) == MODE_SAMPLE) && i_in.present &&
                        (t_kind'(i_in.kind) != KIND_NONE) &&
                        ({1'b0, i_in.action} < 7'(ACTION_COUNT));
    assign out_free   = !r_out_valid || o_out.ready;
    assign walk_go    = !r_walk_end || out_free;

    // Next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (smp_ok) begin
                        n_state = ST_SAMPLE;
                    end else if (t_mode'(i_in.mode) == MODE_START ||
                                 t_mode'(i_in.mode) == MODE_END) begin
                        n_state = ST_WALK_RD;
                        n_idx   = '0;
                    end
                end
            end
            ST_SAMPLE:  n_state = ST_IDLE;
            ST_WALK_RD: n_state = ST_WALK_WR;
            ST_WALK_WR: begin
                if (walk_go) begin
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_WALK_RD;
                        n_idx   = r_idx + 1'b1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Clamp the stored sum to plus or minus one
    always_comb begin
        priority if (rd_data.sum > ONE_Q14) begin
            clamped = ONE_Q14;
        end else if (rd_data.sum < MINUS_ONE_Q14) begin
            clamped = MINUS_ONE_Q14;
        end else begin
            clamped = rd_data.sum;
        end
    end

    // Memory and output controls
    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = r_idx;
        wr_en    = 1'b0;
        wr_addr  = r_idx;
        wr_data  = alu_new;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                rd_en   = in_acc && smp_ok;
                rd_addr = AW'(i_in.action);
            end
            ST_SAMPLE: begin
                wr_en   = 1'b1;
                wr_addr = r_addr;
                wr_data = alu_new;
            end
            ST_WALK_RD: begin
                rd_en = 1'b1;
            end
            ST_WALK_WR: begin
                wr_en    = walk_go;
                out_load = walk_go && r_walk_end;
                if (r_walk_end) begin
                    wr_data.held_now    = rd_data.held_now;
                    wr_data.held_before = rd_data.held_before;
                    wr_data.sum         = clamped;
                end else begin
                    wr_data.held_now    = 1'b0;
                    wr_data.held_before = rd_data.held_now;
                    wr_data.sum         = '0;
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Capture the accepted word; form the product here
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_walk_end         <= (t_mode'(i_in.mode) == MODE_END);
            r_addr             <= AW'(i_in.action);
            r_smp.kind         <= t_kind'(i_in.kind);
            r_smp.down         <= i_in.button_down;
            r_smp.sample_value <= i_in.sample_value;
            r_smp.scale        <= i_in.scale;
            r_smp.product      <= i_in.sample_value * i_in.scale;
        end
    end

    asetk_state_mem #(
        .DEPTH (ACTION_COUNT),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    asetk_sample_alu u_alu (
        .i_smp      (r_smp),
        .i_deadzone (r_deadzone),
        .i_old      (rd_data),
        .o_new      (alu_new)
    );

    // Output word valid: load on a report row, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_action <= 6'(r_idx);
            r_out_held   <= rd_data.held_now;
            r_out_down   <= rd_data.held_now && !rd_data.held_before;
            r_out_up     <= !rd_data.held_now && rd_data.held_before;
            r_out_level  <= LEVEL_W'(clamped);
            r_out_last   <= (r_idx == LAST_IDX);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.report_action = r_out_action;
    assign o_out.held          = r_out_held;
    assign o_out.went_down     = r_out_down;
    assign o_out.went_up       = r_out_up;
    assign o_out.level         = r_out_level;
    assign o_out.last          = r_out_last;

    // Read and write never share a cycle, so no forwarding is needed
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en))
        else $error("memory read and write in the same cycle");

    // An accepted sample goes to the write-back step
    a_sample_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && smp_ok) |=> (r_state == ST_SAMPLE))
        else $error("accepted sample did not reach write-back");

    // Report words come only from a frame end walk
    a_load_end_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_walk_end && r_state == ST_WALK_WR))
        else $error("report word loaded outside a frame end walk");

    // After the last row the block returns to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_idx == LAST_IDX) |=> (r_state == ST_IDLE && o_out.last))
        else $error("frame end walk did not finish on the last row");

endmodule

### hw/rtl/asetk_state_mem.sv
// Action state memory: one entry per action, one read and one write port.
// Depends on asetk_pkg for the entry type.
module asetk_state_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output asetk_pkg::t_entry    o_rd_data,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  asetk_pkg::t_entry    i_wr_data
);
    import asetk_pkg::*;

    t_entry           r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    t_entry           r_rd_data;
    logic             r_rd_valid;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Mark entries written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // Entries never written read as zero
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

### hw/rtl/asetk_sample_alu.sv
// Sample unit: turns one registered sample and the old entry into the new entry.
// Depends on asetk_pkg for the sample and entry types.
module asetk_sample_alu (
    input  asetk_pkg::t_sample          i_smp,
    input  logic [asetk_pkg::DZ_W-1:0]  i_deadzone,
    input  asetk_pkg::t_entry           i_old,
    output asetk_pkg::t_entry           o_new
);
    import asetk_pkg::*;

    logic [31:0]             mag;
    logic [31:0]             mag_rnd;
    logic [SUM_W-1:0]        q;
    logic signed [SUM_W-1:0] axis_val;
    logic                    axis_held;
    logic                    h;
    logic signed [SUM_W-1:0] v;
    logic signed [SUM_W:0]   s;

    // Round the Q4.26 product to Q1.14, ties away from zero
    always_comb begin
        mag       = i_smp.product[31] ? 32'(-i_smp.product) : 32'(i_smp.product);
        mag_rnd   = mag + ROUND_HALF;
        q         = SUM_W'(mag_rnd >> 12);
        axis_val  = i_smp.product[31] ? -$signed(q) : $signed(q);
        axis_held = q > SUM_W'(i_deadzone);
    end

    // Select held bit and value by kind
    always_comb begin
        unique case (i_smp.kind)
            KIND_DIRECT: begin
                h = i_smp.down;
                v = SUM_W'(i_smp.sample_value);
            end
            KIND_BUTTON: begin
                h = i_smp.down;
                v = i_smp.down ? SUM_W'({i_smp.scale, 2'b00}) : '0;
                if (i_smp.down) v = SUM_W'($signed({i_smp.scale, 2'b00}));
            end
            KIND_AXIS: begin
                h = axis_held;
                v = axis_held ? axis_val : '0;
            end
            default: begin
                h = 1'b0;
                v = '0;
            end
        endcase
    end

    // OR the held bit, add with saturation
    always_comb begin
        s = (SUM_W+1)'(i_old.sum) + (SUM_W+1)'(v);
        o_new.held_now    = i_old.held_now | h;
        o_new.held_before = i_old.held_before;
        priority if (s > SUM_MAX) begin
            o_new.sum = SUM_W'(SUM_MAX);
        end else if (s < SUM_MIN) begin
            o_new.sum = SUM_W'(SUM_MIN);
        end else begin
            o_new.sum = SUM_W'(s);
        end
    end

endmodule

### bench/tb_action_state_edge_tracker.sv
`timescale 1ns / 1ps
// Self-checking bench for action_state_edge_tracker: random frames of samples in, report rows out.
// Depends on asetk_pkg and the asetk_in_if / asetk_out_if channel interfaces.
module tb_action_state_edge_tracker;
    import asetk_pkg::*;

    localparam int ACTIONS   = 32;
    localparam int SETTLE    = 2 * ACTIONS + 16;
    localparam int SUM_HI    = 524287;
    localparam int SUM_LO    = -524288;
    localparam int LEVEL_ONE = 16384;

    // One input word as the sender sees it
    typedef struct {
        t_mode             mode;
        logic [5:0]        action;
        t_kind             kind;
        logic              present;
        logic              down;
        logic signed [15:0] sval;
        logic signed [15:0] scale;
    } t_word;

    // One report row the block owes us
    typedef struct {
        int report_action;
        bit held;
        bit went_down;
        bit went_up;
        int level;
        bit last;
    } t_row;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [DZ_W-1:0] i_cfg_wdata;

    asetk_in_if  in_ch ();
    asetk_out_if out_ch ();

    action_state_edge_tracker #(
        .ACTION_COUNT(ACTIONS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // Tracker shadow state
    bit        cur_held [ACTIONS];
    bit        prev_held[ACTIONS];
    int        act_sum  [ACTIONS];
    logic [DZ_W-1:0] dz_reg = DEADZONE_RESET;

    t_word word_q[$];
    t_row  row_q[$];
    t_word cur_word;
    int    words_pending  = 0;
    int    mismatch_count = 0;
    int    send_gap       = 0;
    int    stall_left     = 0;
    bit    in_quiet       = 1'b0;
    bit    out_quiet      = 1'b0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop if the run hangs
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Mostly short idles, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_word mk(t_mode m, int a, t_kind k, bit p, bit d, int sv, int sc);
        t_word w;
        w.mode    = m;
        w.action  = a[5:0];
        w.kind    = k;
        w.present = p;
        w.down    = d;
        w.sval    = sv[15:0];
        w.scale   = sc[15:0];
        return w;
    endfunction

    // Sample word with random content, biased towards the low actions
    function automatic t_word rand_sample();
        int a, r, k, sc;
        r = $urandom_range(0, 99);
        if (r < 50)      a = $urandom_range(0, 7);
        else if (r < 80) a = $urandom_range(0, ACTIONS - 1);
        else if (r < 90) a = ACTIONS - 1;
        else             a = $urandom_range(ACTIONS, 63);
        k  = ($urandom_range(0, 19) == 0) ? KIND_NONE : $urandom_range(0, 2);
        sc = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 65535) - 32768
                                        : $urandom_range(0, 8192) - 4096;
        return mk(MODE_SAMPLE, a, t_kind'(k), $urandom_range(0, 9) != 0,
                  $urandom_range(0, 1), $urandom_range(0, 32768) - 16384, sc);
    endfunction

    task automatic push_word(t_word w);
        word_q.push_back(w);
        words_pending++;
    endtask

    // Well-formed frames with random samples, plus some stray words
    task automatic push_frames(int n);
        int cnt, k;
        t_word w;
        cnt = 0;
        while (cnt < n) begin
            if ($urandom_range(0, 99) < 85) begin
                push_word(mk(MODE_START, 0, KIND_DIRECT, 0, 0, 0, 0));
                k = $urandom_range(0, 12);
                repeat (k) push_word(rand_sample());
                push_word(mk(MODE_END, 0, KIND_DIRECT, 0, 0, 0, 0));
                cnt += k + 2;
            end else begin
                w = rand_sample();
                w.mode = t_mode'($urandom_range(0, 3));
                push_word(w);
                if (w.mode != MODE_NONE) cnt++;
            end
        end
    endtask

    // Advance the shadow tracker by one accepted word
    task automatic track_word(t_word w);
        longint prod, mag, q;
        int     contrib, acc, lv, a;
        bit     h;
        t_row   r;
        case (w.mode)
            MODE_START: begin
                for (int i = 0; i < ACTIONS; i++) begin
                    prev_held[i] = cur_held[i];
                    cur_held[i]  = 1'b0;
                    act_sum[i]   = 0;
                end
            end
            MODE_SAMPLE: begin
                a = w.action;
                if (w.present && a < ACTIONS && w.kind != KIND_NONE) begin
                    h       = 1'b0;
                    contrib = 0;
                    case (w.kind)
                        KIND_DIRECT: begin
                            h       = w.down;
                            contrib = $signed(w.sval);
                        end
                        KIND_BUTTON: begin
                            h       = w.down;
                            contrib = w.down ? 4 * int'($signed(w.scale)) : 0;
                        end
                        default: begin
                            // Q1.14 x Q3.12, round half away from zero back to Q1.14
                            prod = longint'($signed(w.sval)) * longint'($signed(w.scale));
                            mag  = (prod < 0) ? -prod : prod;
                            q    = (mag + 2048) >>> 12;
                            h    = (q > longint'(dz_reg));
                            if (prod < 0) q = -q;
                            contrib = h ? int'(q) : 0;
                        end
                    endcase
                    cur_held[a] |= h;
                    acc = act_sum[a] + contrib;
                    if (acc > SUM_HI) acc = SUM_HI;
                    if (acc < SUM_LO) acc = SUM_LO;
                    act_sum[a] = acc;
                end
            end
            MODE_END: begin
                // Clamp each sum to +/-1 and keep the clamped value
                for (int i = 0; i < ACTIONS; i++) begin
                    lv = act_sum[i];
                    if (lv > LEVEL_ONE)  lv = LEVEL_ONE;
                    if (lv < -LEVEL_ONE) lv = -LEVEL_ONE;
                    act_sum[i]      = lv;
                    r.report_action = i;
                    r.held          = cur_held[i];
                    r.went_down     = cur_held[i] && !prev_held[i];
                    r.went_up       = !cur_held[i] && prev_held[i];
                    r.level         = lv;
                    r.last          = (i == ACTIONS - 1);
                    row_q.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(string fname, int row_idx, int want, logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch on row %0d: expected %0d, got %0d",
                     $time, fname, row_idx, want, got);
            mismatch_count++;
        end
    endtask

    // Drive words from the pending queue with random gaps
    always @(posedge i_clk) begin : drive_words
        logic nxt_valid;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            nxt_valid = in_ch.valid;
            if ($urandom_range(0, 199) == 0) in_quiet = !in_quiet;
            if (in_ch.valid && in_ch.ready) begin
                track_word(cur_word);
                words_pending--;
                nxt_valid = 1'b0;
                send_gap  = in_quiet ? 0 : idle_len();
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (word_q.size() > 0) begin
                    cur_word = word_q.pop_front();
                    in_ch.mode         <= cur_word.mode;
                    in_ch.action       <= cur_word.action;
                    in_ch.kind         <= cur_word.kind;
                    in_ch.present      <= cur_word.present;
                    in_ch.button_down  <= cur_word.down;
                    in_ch.sample_value <= cur_word.sval;
                    in_ch.scale        <= cur_word.scale;
                    nxt_valid = 1'b1;
                end
            end
            in_ch.valid <= nxt_valid;
        end
    end

    // Take report rows with random stalls and check each against the oldest expected row
    always @(posedge i_clk) begin : take_rows
        t_row want;
        logic nxt_ready;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (row_q.size() == 0) begin
                    $display("%0t: unexpected row, expected none, got action %0d level %0d",
                             $time, out_ch.report_action, out_ch.level);
                    mismatch_count++;
                end else begin
                    want = row_q.pop_front();
                    check_field("report_action", want.report_action, want.report_action,
                                out_ch.report_action);
                    check_field("held", want.report_action, want.held, out_ch.held);
                    check_field("went_down", want.report_action, want.went_down,
                                out_ch.went_down);
                    check_field("went_up", want.report_action, want.went_up, out_ch.went_up);
                    check_field("level", want.report_action, want.level, out_ch.level);
                    check_field("last", want.report_action, want.last, out_ch.last);
                end
            end
            if ($urandom_range(0, 199) == 0) out_quiet = !out_quiet;
            if (stall_left > 0) begin
                stall_left--;
                nxt_ready = 1'b0;
            end else begin
                stall_left = out_quiet ? 0 : idle_len();
                nxt_ready  = (stall_left == 0);
            end
            out_ch.ready <= nxt_ready;
        end
    end

    // Hold until every word is taken and every row is back, then let any walk finish
    task automatic wait_drained();
        while (words_pending != 0 || row_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_deadzone(int v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v[DZ_W-1:0];
        dz_reg = v[DZ_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        in_ch.valid        = 1'b0;
        in_ch.mode         = MODE_NONE;
        in_ch.action       = '0;
        in_ch.kind         = KIND_DIRECT;
        in_ch.present      = 1'b0;
        in_ch.button_down  = 1'b0;
        in_ch.sample_value = '0;
        in_ch.scale        = '0;
        out_ch.ready       = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset deadzone
        push_word(mk(MODE_START, 0, KIND_DIRECT, 1, 0, 0, 0));
        // push action 0 past the top of the sum
        repeat (4) push_word(mk(MODE_SAMPLE, 0, KIND_BUTTON, 1, 1, 0, 32767));
        push_word(mk(MODE_SAMPLE, 0, KIND_DIRECT, 1, 1, 16384, 0));
        // push action 1 to the bottom, then past it without holding
        repeat (4) push_word(mk(MODE_SAMPLE, 1, KIND_BUTTON, 1, 1, 0, -32768));
        push_word(mk(MODE_SAMPLE, 1, KIND_DIRECT, 1, 0, -16384, 0));
        // released button adds nothing
        push_word(mk(MODE_SAMPLE, 2, KIND_BUTTON, 1, 0, 0, 1000));
        // axis at the deadzone, just over it, and at full deflection
        push_word(mk(MODE_SAMPLE, 3, KIND_AXIS, 1, 0, 4096, 4096));
        push_word(mk(MODE_SAMPLE, 4, KIND_AXIS, 1, 0, 4097, 4096));
        push_word(mk(MODE_SAMPLE, 5, KIND_AXIS, 1, 0, -16384, -32768));
        // ignored: absent device, action out of range, unused kind, unused mode
        push_word(mk(MODE_SAMPLE, 31, KIND_DIRECT, 0, 1, 100, 0));
        push_word(mk(MODE_SAMPLE, 63, KIND_DIRECT, 1, 1, 100, 0));
        push_word(mk(MODE_SAMPLE, 7, KIND_NONE, 1, 1, 100, 100));
        push_word(mk(MODE_NONE, 8, KIND_DIRECT, 1, 1, 100, 0));
        push_word(mk(MODE_END, 0, KIND_DIRECT, 0, 0, 0, 0));
        // later sample adds to the clamped level of the same frame
        push_word(mk(MODE_SAMPLE, 0, KIND_DIRECT, 1, 0, -100, 0));
        push_word(mk(MODE_END, 0, KIND_DIRECT, 0, 0, 0, 0));
        // empty frame: every held action goes up
        push_word(mk(MODE_START, 0, KIND_DIRECT, 0, 0, 0, 0));
        push_word(mk(MODE_END, 0, KIND_DIRECT, 0, 0, 0, 0));
        wait_drained();

        // Zero deadzone: rounding of the smallest products
        write_deadzone(0);
        push_word(mk(MODE_START, 0, KIND_DIRECT, 0, 0, 0, 0));
        push_word(mk(MODE_SAMPLE, 2, KIND_AXIS, 1, 0, 1, 2048));
        push_word(mk(MODE_SAMPLE, 3, KIND_AXIS, 1, 0, -1, 2048));
        push_word(mk(MODE_SAMPLE, 4, KIND_AXIS, 1, 0, 1, 2047));
        push_word(mk(MODE_END, 0, KIND_DIRECT, 0, 0, 0, 0));
        push_frames(80);
        wait_drained();

        // Deadzone of one: exactly at and just over one
        write_deadzone(16384);
        push_word(mk(MODE_START, 0, KIND_DIRECT, 0, 0, 0, 0));
        push_word(mk(MODE_SAMPLE, 5, KIND_AXIS, 1, 0, 16384, 4096));
        push_word(mk(MODE_SAMPLE, 6, KIND_AXIS, 1, 0, 16384, 4097));
        push_word(mk(MODE_END, 0, KIND_DIRECT, 0, 0, 0, 0));
        push_frames(80);
        // let every row come home before sending more
        wait_drained();
        push_frames(50);
        wait_drained();

        write_deadzone($urandom_range(0, 16384));
        push_frames(60);
        wait_drained();

        if (mismatch_count == 0 && row_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/asetk_pkg.sv
hw/rtl/asetk_if.sv
hw/rtl/asetk_state_mem.sv
hw/rtl/asetk_sample_alu.sv
hw/rtl/action_state_edge_tracker.sv
bench/tb_action_state_edge_tracker.sv
